[hdl/osm_pkg.sv]
// Package for the order-statistic multiset: operation and status codes,
// sequencer states, cell flag and command structs. No dependencies.
package osm_pkg;

  localparam int unsigned CapacityDef = 64;
  localparam int unsigned KeyW        = 64;
  localparam int unsigned PosW        = 7;
  localparam int unsigned OutCntW     = 7;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_FIND   = 3'd2,
    OP_RANK   = 3'd3,
    OP_SELECT = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2,
    ST_RANGE  = 2'd3
  } status_e;

  typedef enum logic {
    SEQ_IDLE  = 1'b0,
    SEQ_APPLY = 1'b1
  } seq_state_e;

  // per-cell compare results, captured when a word is accepted
  typedef struct packed {
    logic lt;   // occupied and stored key below search key
    logic le;   // occupied and stored key at or below search key
    logic sel;  // occupied and this cell is the requested position
  } cell_flags_t;

  // broadcast command to every cell
  typedef struct packed {
    logic capture;
    logic ins;
    logic del;
  } cell_cmd_t;

endpackage

[hdl/order_statistic_multiset.sv]
// Top level of the order-statistic multiset: sequencer, row of osm_cell,
// osm_reduce and the output register. Depends on osm_pkg.
//
//  channel | valid      | stall       | payload
//  in      | in_valid_i | in_stall_o  | op_i, key_i, position_i
//  out     | out_valid_o| out_stall_i | value_o, rank_value_o, found_o, count_o, status_o
//
// Per word: the accept edge latches the op and every cell compares its key in
// parallel; the apply step shifts the row, loads the result and frees the input.
// The apply step waits while a previous result is held by out_stall_i.
// Reset empties the store (count zero); cell keys are not cleared.
module order_statistic_multiset #(
  parameter int unsigned CAPACITY = osm_pkg::CapacityDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [2:0]                          op_i,
  input  logic signed [osm_pkg::KeyW-1:0]     key_i,
  input  logic [osm_pkg::PosW-1:0]            position_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [osm_pkg::KeyW-1:0]     value_o,
  output logic [osm_pkg::PosW-1:0]            rank_value_o,
  output logic                                found_o,
  output logic [osm_pkg::OutCntW-1:0]         count_o,
  output logic [1:0]                          status_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = (CntW + 1 > osm_pkg::PosW) ? CntW + 1 : osm_pkg::PosW;

  osm_pkg::seq_state_e state_q, state_d;
  osm_pkg::op_e        op_q;
  logic signed [osm_pkg::KeyW-1:0] key_q;
  logic [CntW-1:0]     count_q, count_d;

  logic                out_valid_q, out_valid_d;
  logic signed [osm_pkg::KeyW-1:0] value_q, value_d;
  logic [osm_pkg::PosW-1:0] rank_q, rank_d;
  logic                found_q, found_d;
  osm_pkg::status_e    status_q, status_d;

  osm_pkg::cell_cmd_t  cmd;
  osm_pkg::cell_flags_t flags [CAPACITY];
  logic signed [osm_pkg::KeyW-1:0] cell_key [CAPACITY];
  logic [CAPACITY-1:0] occ;

  logic                accept;
  logic                can_out;
  logic                red_found;
  logic [CntW-1:0]     red_below;
  logic                red_sel_hit;
  logic signed [osm_pkg::KeyW-1:0] red_sel_key;
  logic [CntW:0]       rank_full;

  assign accept     = in_valid_i && (state_q == osm_pkg::SEQ_IDLE);
  assign in_stall_o = (state_q != osm_pkg::SEQ_IDLE);
  assign can_out    = !out_valid_q || !out_stall_i;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    assign occ[g] = (count_q > CntW'(g));

    osm_cell #(
      .Idx  (g),
      .IdxW (IdxW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .occ_i       (occ[g]),
      .cmp_key_i   (key_i),
      .pos_i       (position_i),
      .ins_key_i   (key_q),
      .left_key_i  ((g == 0) ? key_q : cell_key[(g == 0) ? 0 : g - 1]),
      .left_le_i   ((g == 0) ? 1'b1 : flags[(g == 0) ? 0 : g - 1].le),
      .right_key_i (cell_key[(g == CAPACITY - 1) ? g : g + 1]),
      .key_o       (cell_key[g]),
      .flags_o     (flags[g])
    );
  end

  osm_reduce #(
    .Capacity (CAPACITY),
    .CntW     (CntW)
  ) u_reduce (
    .flags_i   (flags),
    .keys_i    (cell_key),
    .found_o   (red_found),
    .below_o   (red_below),
    .sel_hit_o (red_sel_hit),
    .sel_key_o (red_sel_key)
  );

  assign rank_full = {1'b0, red_below} + (CntW + 1)'(1);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    value_d     = value_q;
    rank_d      = rank_q;
    found_d     = found_q;
    status_d    = status_q;
    cmd         = '0;
    cmd.capture = accept;

    case (state_q)
      osm_pkg::SEQ_IDLE: begin
        if (accept) begin
          state_d = osm_pkg::SEQ_APPLY;
        end
      end
      osm_pkg::SEQ_APPLY: begin
        if (can_out) begin
          state_d     = osm_pkg::SEQ_IDLE;
          out_valid_d = 1'b1;
          value_d     = '0;
          rank_d      = '0;
          found_d     = 1'b0;
          status_d    = osm_pkg::ST_OK;
          case (op_q)
            osm_pkg::OP_INSERT: begin
              if (count_q == CntW'(CAPACITY)) begin
                status_d = osm_pkg::ST_FULL;
              end else begin
                cmd.ins = 1'b1;
                count_d = count_q + CntW'(1);
              end
            end
            osm_pkg::OP_DELETE: begin
              if (red_found) begin
                cmd.del = 1'b1;
                value_d = key_q;
                count_d = count_q - CntW'(1);
              end else begin
                status_d = osm_pkg::ST_ABSENT;
              end
            end
            osm_pkg::OP_FIND: begin
              found_d = red_found;
            end
            osm_pkg::OP_RANK: begin
              rank_d = osm_pkg::PosW'(rank_full);
            end
            osm_pkg::OP_SELECT: begin
              if (red_sel_hit) begin
                value_d = red_sel_key;
              end else begin
                status_d = osm_pkg::ST_RANGE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_d = osm_pkg::SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= osm_pkg::SEQ_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= osm_pkg::op_e'(op_i);
      key_q <= key_i;
    end
    value_q  <= value_d;
    rank_q   <= rank_d;
    found_q  <= found_d;
    status_q <= status_d;
  end

  assign out_valid_o  = out_valid_q;
  assign value_o      = value_q;
  assign rank_value_o = rank_q;
  assign found_o      = found_q;
  assign count_o      = osm_pkg::OutCntW'(count_q);
  assign status_o     = status_q;

endmodule

[hdl/osm_cell.sv]
// One cell of the sorted key row: holds one key and its compare flags.
// Shifts right on insert, left on delete. Depends on osm_pkg.
module osm_cell #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned IdxW = 7
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  osm_pkg::cell_cmd_t               cmd_i,
  input  logic                             occ_i,
  input  logic signed [osm_pkg::KeyW-1:0]  cmp_key_i,
  input  logic [osm_pkg::PosW-1:0]         pos_i,
  input  logic signed [osm_pkg::KeyW-1:0]  ins_key_i,
  input  logic signed [osm_pkg::KeyW-1:0]  left_key_i,
  input  logic                             left_le_i,
  input  logic signed [osm_pkg::KeyW-1:0]  right_key_i,
  output logic signed [osm_pkg::KeyW-1:0]  key_o,
  output osm_pkg::cell_flags_t             flags_o
);

  logic signed [osm_pkg::KeyW-1:0] key_q, key_d;
  osm_pkg::cell_flags_t            flags_q, flags_d;
  logic [IdxW-1:0]                 pos_ext;

  assign pos_ext = IdxW'(pos_i);

  always_comb begin
    flags_d = flags_q;
    if (cmd_i.capture) begin
      flags_d.lt  = occ_i && (key_q < cmp_key_i);
      flags_d.le  = occ_i && (key_q <= cmp_key_i);
      flags_d.sel = occ_i && (pos_ext == IdxW'(Idx + 1));
    end
  end

  always_comb begin
    key_d = key_q;
    if (cmd_i.ins && !flags_q.le) begin
      // first cell above the key takes the new key, the rest move up
      key_d = left_le_i ? ins_key_i : left_key_i;
    end else if (cmd_i.del && !flags_q.lt) begin
      key_d = right_key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o   = key_q;
  assign flags_o = flags_q;

endmodule

[hdl/osm_reduce.sv]
// Collects the cell flags: boundary of the below-key run (rank, presence)
// and the key of the selected cell. Depends on osm_pkg.
module osm_reduce #(
  parameter int unsigned Capacity = osm_pkg::CapacityDef,
  parameter int unsigned CntW     = $clog2(Capacity + 1)
) (
  input  osm_pkg::cell_flags_t             flags_i [Capacity],
  input  logic signed [osm_pkg::KeyW-1:0]  keys_i  [Capacity],
  output logic                             found_o,
  output logic [CntW-1:0]                  below_o,
  output logic                             sel_hit_o,
  output logic signed [osm_pkg::KeyW-1:0]  sel_key_o
);

  logic bnd;

  always_comb begin
    found_o   = 1'b0;
    below_o   = '0;
    sel_hit_o = 1'b0;
    sel_key_o = '0;
    bnd       = 1'b0;
    for (int i = 0; i < Capacity; i++) begin
      // lt is a thermometer over the sorted row; bnd marks its end
      bnd = ((i == 0) ? 1'b1 : flags_i[(i == 0) ? 0 : i - 1].lt) && !flags_i[i].lt;
      if (bnd) begin
        below_o = below_o | CntW'(i);
        found_o = found_o | flags_i[i].le;
      end
      if (flags_i[i].sel) begin
        sel_hit_o = 1'b1;
        sel_key_o = sel_key_o | keys_i[i];
      end
    end
    if (flags_i[Capacity-1].lt) begin
      below_o = below_o | CntW'(Capacity);
    end
  end

endmodule

[hdl/osm_checker.sv]
// Port-level checks for order_statistic_multiset, bound to the top level.
// Depends on osm_pkg.
module osm_checker #(
  parameter int unsigned CAPACITY = osm_pkg::CapacityDef
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic signed [osm_pkg::KeyW-1:0] value_o,
  input logic                            found_o,
  input logic [osm_pkg::OutCntW-1:0]     count_o,
  input logic [1:0]                      status_o
);

  // a held word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(value_o) && $stable(count_o))
    else $error("held result word changed");

  // an accepted word blocks the input for its apply step
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == osm_pkg::ST_FULL)
      |-> count_o == osm_pkg::OutCntW'(CAPACITY))
    else $error("full flag with store not full");

  a_err_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != osm_pkg::ST_OK) |-> value_o == '0 && !found_o)
    else $error("error result carries a value");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (CAPACITY > 127) || (count_o <= osm_pkg::OutCntW'(CAPACITY)))
    else $error("count above capacity");

endmodule

bind order_statistic_multiset osm_checker #(.CAPACITY(CAPACITY)) u_osm_checker (.*);

[tb/order_statistic_multiset_test.sv]
// Self-checking testbench for order_statistic_multiset: directed and random words with
// a scoreboard that mirrors the sorted multiset. Depends on osm_pkg and the RTL only.
module order_statistic_multiset_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          Capacity   = osm_pkg::CapacityDef;
  localparam int          CycleLimit = 200000;
  localparam int          HoldCycles = 200;
  localparam logic [2:0]  OP_SPARE_LO = 3'd5;
  localparam logic [2:0]  OP_SPARE_HI = 3'd7;
  localparam logic signed [osm_pkg::KeyW-1:0] KEY_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [osm_pkg::KeyW-1:0] KEY_MAX = 64'sh7fff_ffff_ffff_ffff;

  typedef enum {MIX_GROW, MIX_BALANCED, MIX_SHRINK} mix_e;

  typedef struct {
    logic signed [osm_pkg::KeyW-1:0] value;
    logic [osm_pkg::PosW-1:0]        rank_value;
    logic                            found;
    logic [osm_pkg::OutCntW-1:0]     count;
    osm_pkg::status_e                status;
  } osm_result_t;

  class multiset_scoreboard;
    logic signed [osm_pkg::KeyW-1:0] keys [Capacity];
    int          held;
    osm_result_t expected_q [$];
    int unsigned errors;
    int unsigned checked;
    int unsigned words;
    int unsigned flag_seen [4];

    function new();
      held    = 0;
      errors  = 0;
      checked = 0;
      words   = 0;
      foreach (flag_seen[i]) flag_seen[i] = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // apply one accepted word to the mirror store and queue its result
    function void note_word(logic [2:0] op, logic signed [osm_pkg::KeyW-1:0] key,
                            logic [osm_pkg::PosW-1:0] pos);
      osm_result_t r;
      int below;
      int upto;
      r.value      = '0;
      r.rank_value = '0;
      r.found      = 1'b0;
      r.status     = osm_pkg::ST_OK;
      below = 0;
      upto  = 0;
      words++;
      for (int i = 0; i < held; i++) begin
        if (keys[i] < key) below++;
        if (keys[i] <= key) upto++;
      end
      case (op)
        osm_pkg::OP_INSERT: begin
          if (held >= Capacity) begin
            r.status = osm_pkg::ST_FULL;
          end else begin
            for (int i = held; i > upto; i--) keys[i] = keys[i-1];
            keys[upto] = key;
            held++;
          end
        end
        osm_pkg::OP_DELETE: begin
          if (below < held && keys[below] == key) begin
            r.value = key;
            for (int i = below; i < held - 1; i++) keys[i] = keys[i+1];
            held--;
          end else begin
            r.status = osm_pkg::ST_ABSENT;
          end
        end
        osm_pkg::OP_FIND: r.found = (below < held && keys[below] == key);
        osm_pkg::OP_RANK: r.rank_value = osm_pkg::PosW'(below + 1);
        osm_pkg::OP_SELECT: begin
          if (pos == 0 || pos > held) r.status = osm_pkg::ST_RANGE;
          else r.value = keys[pos-1];
        end
        default: ;
      endcase
      r.count = osm_pkg::OutCntW'(held);
      expected_q.push_back(r);
    endfunction

    function void compare_field(string field, logic signed [osm_pkg::KeyW-1:0] exp_v,
                                logic signed [osm_pkg::KeyW-1:0] act_v);
      if (act_v !== exp_v) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(logic signed [osm_pkg::KeyW-1:0] value,
                               logic [osm_pkg::PosW-1:0] rank_value, logic found,
                               logic [osm_pkg::OutCntW-1:0] count, logic [1:0] status);
      osm_result_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result word, value %0d status %0d", $time, value, status);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      checked++;
      flag_seen[int'(exp_r.status)]++;
      compare_field("value", exp_r.value, value);
      compare_field("rank_value", exp_r.rank_value, rank_value);
      compare_field("found", exp_r.found, found);
      compare_field("count", exp_r.count, count);
      compare_field("status", exp_r.status, status);
    endfunction
  endclass

  logic                            clk_i;
  logic                            rst_ni;
  logic                            in_valid_i;
  logic                            in_stall_o;
  logic [2:0]                      op_i;
  logic signed [osm_pkg::KeyW-1:0] key_i;
  logic [osm_pkg::PosW-1:0]        position_i;
  logic                            out_valid_o;
  logic                            out_stall_i;
  logic signed [osm_pkg::KeyW-1:0] value_o;
  logic [osm_pkg::PosW-1:0]        rank_value_o;
  logic                            found_o;
  logic [osm_pkg::OutCntW-1:0]     count_o;
  logic [1:0]                      status_o;

  multiset_scoreboard              sb;
  logic signed [osm_pkg::KeyW-1:0] key_pool [8];
  logic                            tx_quiet = 1'b0;
  logic                            rx_quiet = 1'b0;
  logic                            hold_req = 1'b0;
  int unsigned                     cycles = 0;

  order_statistic_multiset #(
    .CAPACITY(Capacity)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .key_i       (key_i),
    .position_i  (position_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .rank_value_o(rank_value_o),
    .found_o     (found_o),
    .count_o     (count_o),
    .status_o    (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("order_statistic_multiset_test: FAIL");
      $finish;
    end
  end

  // receiver: random stalls, a quiet stretch, and one long hold-off on request
  initial begin : result_sink
    int unsigned n;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        for (n = 0; n < HoldCycles; n++) @(negedge clk_i);
      end else begin
        out_stall_i <= !rx_quiet && ($urandom_range(0, 99) < 16);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(value_o, rank_value_o, found_o, count_o, status_o);
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic drive_word(input logic [2:0] op,
                            input logic signed [osm_pkg::KeyW-1:0] key,
                            input logic [osm_pkg::PosW-1:0] pos);
    while (!tx_quiet && $urandom_range(0, 99) < 16) begin
      in_valid_i <= 1'b0;
      key_i      <= {$urandom, $urandom};
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    key_i      <= key;
    position_i <= pos;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_word(op, key, pos);
    @(negedge clk_i);
  endtask

  // stored keys give delete and find hits; the pool gives duplicates and extremes
  function automatic logic signed [osm_pkg::KeyW-1:0] pick_key(int stored_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (sb.held > 0 && roll < stored_pct) return sb.keys[$urandom_range(0, sb.held - 1)];
    if (roll < stored_pct + 30) return key_pool[$urandom_range(0, 7)];
    return {$urandom, $urandom};
  endfunction

  task automatic random_word(input mix_e mix);
    logic [2:0]                      op;
    logic signed [osm_pkg::KeyW-1:0] key;
    logic [osm_pkg::PosW-1:0]        pos;
    int                              roll;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_GROW:   op = (roll < 75) ? osm_pkg::OP_INSERT
                                   : 3'($urandom_range(osm_pkg::OP_DELETE, osm_pkg::OP_SELECT));
      MIX_SHRINK: op = (roll < 65) ? osm_pkg::OP_DELETE
                                   : 3'($urandom_range(osm_pkg::OP_FIND, osm_pkg::OP_SELECT));
      default:    op = (roll < 6) ? 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI))
                                  : 3'($urandom_range(osm_pkg::OP_INSERT, osm_pkg::OP_SELECT));
    endcase
    key = pick_key((mix == MIX_SHRINK) ? 80 : 40);
    if (sb.held > 0 && $urandom_range(0, 99) < 75) begin
      pos = osm_pkg::PosW'($urandom_range(1, sb.held));
    end else begin
      pos = osm_pkg::PosW'($urandom_range(0, 127));
    end
    drive_word(op, key, pos);
  endtask

  initial begin : stimulus
    int ph;
    int n;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    op_i       = osm_pkg::OP_INSERT;
    key_i      = '0;
    position_i = '0;
    sb = new();
    key_pool[0] = KEY_MIN;
    key_pool[1] = KEY_MAX;
    key_pool[2] = '0;
    key_pool[3] = -64'sd1;
    key_pool[4] = 64'sd1;
    for (n = 5; n < 8; n++) key_pool[n] = {$urandom, $urandom};
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // empty store, extremes, duplicates, all flags but full, spare op codes
    drive_word(osm_pkg::OP_SELECT, '0, 7'd1);
    drive_word(osm_pkg::OP_DELETE, '0, 7'd0);
    drive_word(osm_pkg::OP_FIND, '0, 7'd0);
    drive_word(osm_pkg::OP_RANK, KEY_MAX, 7'd0);
    drive_word(osm_pkg::OP_INSERT, KEY_MIN, 7'd0);
    drive_word(osm_pkg::OP_INSERT, KEY_MAX, 7'd0);
    drive_word(osm_pkg::OP_INSERT, '0, 7'd0);
    drive_word(osm_pkg::OP_INSERT, -64'sd1, 7'd0);
    drive_word(osm_pkg::OP_INSERT, '0, 7'd0);
    drive_word(osm_pkg::OP_RANK, '0, 7'd0);
    drive_word(osm_pkg::OP_RANK, KEY_MAX, 7'd0);
    drive_word(osm_pkg::OP_FIND, KEY_MIN, 7'd0);
    drive_word(osm_pkg::OP_FIND, 64'sd1, 7'd0);
    drive_word(osm_pkg::OP_SELECT, KEY_MAX, 7'd1);
    drive_word(osm_pkg::OP_SELECT, '0, 7'd5);
    drive_word(osm_pkg::OP_SELECT, '0, 7'd6);
    drive_word(osm_pkg::OP_SELECT, '0, 7'd0);
    drive_word(osm_pkg::OP_SELECT, '0, 7'd127);
    drive_word(osm_pkg::OP_DELETE, '0, 7'd0);
    drive_word(osm_pkg::OP_DELETE, 64'sd5, 7'd0);
    drive_word(OP_SPARE_LO, KEY_MAX, 7'd127);
    drive_word(OP_SPARE_LO + 3'd1, '0, 7'd0);
    drive_word(OP_SPARE_HI, -64'sd1, 7'd64);
    drive_word(osm_pkg::OP_DELETE, KEY_MIN, 7'd0);
    drive_word(osm_pkg::OP_RANK, KEY_MIN, 7'd0);

    // grow phases run into the full store, shrink phases drain it
    for (ph = 0; ph < 9; ph++) begin
      tx_quiet = (ph == 4);
      rx_quiet = (ph == 4);
      for (n = 0; n < 100; n++) begin
        if (ph == 1 && n == 40) hold_req = 1'b1;
        random_word(mix_e'(ph % 3));
      end
      if (ph == 5) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
        while (sb.pending() != 0) @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("covered %0d words and %0d checked results, with %0d full, %0d absent",
             sb.words, sb.checked, sb.flag_seen[osm_pkg::ST_FULL],
             sb.flag_seen[osm_pkg::ST_ABSENT]);
    $display("and %0d out-of-range flags; %0d mismatches",
             sb.flag_seen[osm_pkg::ST_RANGE], sb.errors);
    if (sb.errors == 0) begin
      $display("order_statistic_multiset_test: PASS");
    end else begin
      $display("order_statistic_multiset_test: FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/osm_pkg.sv
hdl/osm_cell.sv
hdl/osm_reduce.sv
hdl/order_statistic_multiset.sv
hdl/osm_checker.sv
tb/order_statistic_multiset_test.sv
